// ===== hw/rtl/edge_interrupt_line_debounce_macros.svh =====
// -----------------------------------------------------------------------------
// edge_interrupt_line_debounce_macros.svh
// Assertion macros shared by the interrupt line debounce block.
// -----------------------------------------------------------------------------
`ifndef EDGE_INTERRUPT_LINE_DEBOUNCE_MACROS_SVH
`define EDGE_INTERRUPT_LINE_DEBOUNCE_MACROS_SVH

// Antecedent in this cycle implies consequent in the same cycle.
`define EILD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define EILD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/eild_pkg.sv =====
// -----------------------------------------------------------------------------
// eild_pkg
// Types and constants for the interrupt line debounce block.
// -----------------------------------------------------------------------------
package eild_pkg;

  // Fixed field widths
  localparam int TIME_WIDTH = 48;
  localparam int THR_WIDTH  = 32;
  localparam int PORT_WIDTH = 4;
  localparam int LINE_WIDTH = 4;

  // Request codes
  localparam logic [1:0] REQ_ATTACH = 2'd0;
  localparam logic [1:0] REQ_DETACH = 2'd1;
  localparam logic [1:0] REQ_EVENT  = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Input item
  typedef struct packed {
    logic [1:0]            req_type;
    logic [PORT_WIDTH-1:0] port;
    logic [LINE_WIDTH-1:0] line;
    logic                  level;
    logic [THR_WIDTH-1:0]  debounce_ticks;
    logic [TIME_WIDTH-1:0] now_ticks;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic                             status;
    logic                             notify;
    logic [PORT_WIDTH+LINE_WIDTH-1:0] pin_index;
    logic                             pin_level;
  } out_item_t;

endpackage

// ===== hw/rtl/eild_line_table.sv =====
// -----------------------------------------------------------------------------
// eild_line_table
// Per-line routing, enable, threshold and timestamp store with the
// attach / detach / event decision; only some fired items update the state.
// -----------------------------------------------------------------------------
module eild_line_table
  import eild_pkg::*;
#(
  parameter int NUM_LINES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  in_item_t  req,
  output out_item_t res
);

  localparam int IDX_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;

  // Line state: routing and enable are control, threshold and time are payload
  logic [PORT_WIDTH-1:0] sel_r  [NUM_LINES];
  logic [NUM_LINES-1:0]  en_r;
  logic [THR_WIDTH-1:0]  thr_r  [NUM_LINES];
  logic [TIME_WIDTH-1:0] last_r [NUM_LINES];

  logic [IDX_W-1:0]      idx;
  logic                  line_ok;
  logic [PORT_WIDTH-1:0] cur_sel;
  logic                  cur_en;
  logic [THR_WIDTH-1:0]  cur_thr;
  logic [TIME_WIDTH-1:0] cur_last;
  logic                  port_match;
  logic                  attach_ok;
  logic                  attach_busy;
  logic                  detach_hit;
  logic                  ev_hit;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  thr_zero;
  logic                  elapsed_ok;
  logic                  deliver;
  logic                  stamp;

  // Line lookup
  assign idx      = IDX_W'(req.line);
  assign line_ok  = ({2'b00, req.line} < 6'(NUM_LINES));
  assign cur_sel  = sel_r[idx];
  assign cur_en   = en_r[idx];
  assign cur_thr  = thr_r[idx];
  assign cur_last = last_r[idx];

  // Request decode
  assign port_match  = (cur_sel == req.port);
  assign attach_ok   = fire && line_ok && (req.req_type == REQ_ATTACH)
                       && (port_match || !cur_en);
  assign attach_busy = fire && line_ok && (req.req_type == REQ_ATTACH)
                       && !port_match && cur_en;
  assign detach_hit  = fire && line_ok && (req.req_type == REQ_DETACH) && port_match;
  assign ev_hit      = fire && line_ok && (req.req_type == REQ_EVENT)
                       && cur_en && port_match;

  // Debounce: elapsed time wraps modulo 2^TIME_WIDTH
  assign elapsed    = req.now_ticks - cur_last;
  assign thr_zero   = (cur_thr == '0);
  assign elapsed_ok = (|elapsed[TIME_WIDTH-1:THR_WIDTH])
                      || (elapsed[THR_WIDTH-1:0] >= cur_thr);
  assign deliver    = ev_hit && (thr_zero || elapsed_ok);
  assign stamp      = ev_hit && !thr_zero && elapsed_ok;

  // Result fields
  always_comb begin
    res.status    = attach_busy;
    res.notify    = deliver;
    res.pin_index = deliver ? {req.port, req.line} : '0;
    res.pin_level = deliver ? req.level : 1'b0;
  end

  // Routing and enable update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LINES; i++) begin
        sel_r[IDX_W'(i)] <= '0;
      end
      en_r <= '0;
    end else if (attach_ok) begin
      sel_r[idx] <= req.port;
      en_r[idx]  <= 1'b1;
    end else if (detach_hit) begin
      en_r[idx] <= 1'b0;
    end
  end

  // Threshold and timestamp update
  always_ff @(posedge clk) begin
    if (attach_ok) begin
      thr_r[idx]  <= req.debounce_ticks;
      last_r[idx] <= req.now_ticks;
    end else if (stamp) begin
      last_r[idx] <= req.now_ticks;
    end
  end

endmodule

// ===== hw/rtl/edge_interrupt_line_debounce.sv =====
// -----------------------------------------------------------------------------
// edge_interrupt_line_debounce
// Sixteen-line external interrupt controller with per-line debounce. Each
// request (attach, detach or pin change event) is taken into an input
// register, resolved against the line table and written to a result
// register; one result comes back for every request. The block takes one
// request per clock when the result side does not stall. That rate is set
// by the read-modify-write of the line table, which lets back-to-back
// requests to the same line see each other's updates. Lines at or above
// NUM_LINES, and unknown request codes, return an all-zero result.
// -----------------------------------------------------------------------------
`include "edge_interrupt_line_debounce_macros.svh"

module edge_interrupt_line_debounce
  import eild_pkg::*;
#(
  parameter int NUM_LINES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      in_vld_r;
  in_item_t  in_r;
  logic      out_vld_r;
  out_item_t out_r;
  logic      advance;
  logic      fire;
  out_item_t res;

  // Stage control: the table stage moves when the result register frees up
  assign advance  = !out_vld_r || out_ready;
  assign fire     = in_vld_r && advance;
  assign in_ready = !in_vld_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  // Line table and decision
  eild_line_table #(
    .NUM_LINES(NUM_LINES)
  ) u_table (
    .clk  (clk),
    .rst_n(rst_n),
    .fire (fire),
    .req  (in_r),
    .res  (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // Checks
  `EILD_ASSERT_NEXT(a_fire_gives_result, fire, out_vld_r, "processed item left no result")
  `EILD_ASSERT_NOW(a_notify_no_status, out_vld_r && out_r.notify, !out_r.status, "notify with status")
  `EILD_ASSERT_NOW(a_quiet_fields_zero, out_vld_r && !out_r.notify, (out_r.pin_index == '0) && !out_r.pin_level, "pin fields set without notify")
  `EILD_ASSERT_NOW(a_stall_source, !in_ready, in_vld_r && out_vld_r && !out_ready, "input stalled without backpressure")

endmodule
